@@ design/tpm_pkg.sv @@
// tpm_pkg: shared types, constants and helpers of the tilt PID motor mixer.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package tpm_pkg;

  // CORDIC iteration count and the arctangent table it walks
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_RUN   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int CNT_W        = $clog2(CORDIC_RUN + 1);
  localparam int IDX_W        = $clog2(TABLE_LEN);

  // datapath widths
  localparam int RATE_W  = 34;  // scaled gyro rate, Q18.16
  localparam int ANG_W   = 32;  // angles, Q16.16
  localparam int XY_W    = 36;  // CORDIC vector with gain headroom
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 23;
  localparam int WIDE_W  = 58;  // products and the PID sum
  localparam int N_W     = 20;  // remap numerator

  // fixed-point constants (Q16.16 unless noted)
  localparam logic signed [16:0]        K_RATE  = 17'sd40042;
  localparam logic signed [MUL_B_W-1:0] K_DT    = 23'sd655;
  localparam logic signed [MUL_B_W-1:0] K_BETA  = 23'sd3277;
  localparam logic signed [MUL_B_W-1:0] K_ALPHA = 23'sd62259;
  // ceil(2^31 / 2000): exact floor division by 2000 for numerators below 2^20
  localparam logic signed [MUL_B_W-1:0] K_RECIP = 23'sd1073742;
  localparam int RECIP_SH = 31;
  localparam logic signed [ANG_W-1:0]   DEG180  = 32'sd11796480;

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_RIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT  = 3'd6;

  typedef struct packed {
    logic signed [15:0] gyro_rate_offset;
    logic [15:0]        prop_gain;
    logic [15:0]        integral_gain;
    logic [15:0]        deriv_gain;
    logic [7:0]         base_speed_left;
    logic [7:0]         base_speed_right;
    logic [7:0]         duty_limit;
  } cfg_t;

  // one classified sample: scaled rate and accelerometer angle
  typedef struct packed {
    logic signed [RATE_W-1:0] rate;
    logic signed [ANG_W-1:0]  acc;
  } sample_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_ITER,
    FR_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_RMUL,
    BK_PRED,
    BK_ALPHA,
    BK_TILT,
    BK_ERR,
    BK_IMUL,
    BK_INTEG,
    BK_SUMP,
    BK_SUMI,
    BK_D100,
    BK_SUMD,
    BK_OUT,
    BK_RECIP,
    BK_EMIT
  } back_state_t;

  // atan(2^-i) in degrees, Q16.16
  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 32'sd2949120;
      5'd1:    v = 32'sd1740967;
      5'd2:    v = 32'sd919879;
      5'd3:    v = 32'sd466945;
      5'd4:    v = 32'sd234379;
      5'd5:    v = 32'sd117304;
      5'd6:    v = 32'sd58666;
      5'd7:    v = 32'sd29335;
      5'd8:    v = 32'sd14668;
      5'd9:    v = 32'sd7334;
      5'd10:   v = 32'sd3667;
      5'd11:   v = 32'sd1833;
      5'd12:   v = 32'sd917;
      5'd13:   v = 32'sd458;
      5'd14:   v = 32'sd229;
      5'd15:   v = 32'sd115;
      5'd16:   v = 32'sd57;
      5'd17:   v = 32'sd29;
      5'd18:   v = 32'sd14;
      5'd19:   v = 32'sd7;
      5'd20:   v = 32'sd4;
      5'd21:   v = 32'sd2;
      5'd22:   v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if ((&v[WIDE_W-1:31]) || ~(|v[WIDE_W-1:31])) begin
      r = v[31:0];
    end else if (v[WIDE_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

@@ design/tpm_front.sv @@
// tpm_front: accepts sensor samples, scales the gyro rate and runs the
// iterative CORDIC atan2. Depends on tpm_pkg.
`timescale 1ns / 1ps

module tpm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic signed [15:0]   in_accel_y,
  input  logic signed [15:0]   in_accel_z,
  input  logic signed [15:0]   in_gyro_x,
  input  logic signed [15:0]   gyro_rate_offset,
  output logic                 q_push,
  output tpm_pkg::sample_t     q_data,
  input  tpm_pkg::q_stat_t     q_stat
);

  tpm_pkg::front_state_t state_r, state_nxt;

  logic signed [tpm_pkg::XY_W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [tpm_pkg::ANG_W-1:0]  z_r, z_nxt;
  logic signed [tpm_pkg::RATE_W-1:0] rate_r, rate_nxt;
  logic [tpm_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;

  logic                              accept;
  logic                              zero_vec;
  logic                              step_last;
  logic signed [16:0]                neg_ay, az_ext, gx_ext, off_ext, rdiff;
  logic signed [tpm_pkg::XY_W-1:0]   x0, y0, xs, ys;
  logic signed [tpm_pkg::ANG_W-1:0]  tab;

  assign accept    = in_push && (state_r == tpm_pkg::FR_IDLE);
  assign zero_vec  = (in_accel_y == 16'sd0) && (in_accel_z == 16'sd0);
  assign step_last = (cnt_r == tpm_pkg::CNT_W'(tpm_pkg::CORDIC_RUN - 1));

  // start vector: (accel_z, -accel_y) in Q16.16
  assign neg_ay = -17'(in_accel_y);
  assign az_ext = 17'(in_accel_z);
  assign gx_ext = 17'(in_gyro_x);
  assign off_ext = 17'(gyro_rate_offset);
  assign rdiff  = gx_ext - off_ext;
  assign x0     = tpm_pkg::XY_W'(az_ext) <<< 16;
  assign y0     = tpm_pkg::XY_W'(neg_ay) <<< 16;

  // one micro-rotation per cycle
  assign xs  = x_r >>> cnt_r;
  assign ys  = y_r >>> cnt_r;
  assign tab = tpm_pkg::atan_lut(tpm_pkg::IDX_W'(cnt_r));

  // datapath
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    rate_nxt = rate_r;
    if (accept) begin
      rate_nxt = rdiff * tpm_pkg::K_RATE;
      cnt_nxt  = '0;
      if (in_accel_z[15]) begin
        // left half plane: turn by 180 degrees first
        x_nxt = -x0;
        y_nxt = -y0;
        z_nxt = neg_ay[16] ? -tpm_pkg::DEG180 : tpm_pkg::DEG180;
      end else begin
        x_nxt = x0;
        y_nxt = y0;
        z_nxt = '0;
      end
    end else if (state_r == tpm_pkg::FR_ITER) begin
      cnt_nxt = cnt_r + 1'b1;
      if (!y_r[tpm_pkg::XY_W-1]) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + tab;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - tab;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpm_pkg::FR_IDLE: if (in_push) state_nxt = zero_vec ? tpm_pkg::FR_PUSH : tpm_pkg::FR_ITER;
      tpm_pkg::FR_ITER: if (step_last) state_nxt = tpm_pkg::FR_PUSH;
      tpm_pkg::FR_PUSH: if (!q_stat.full) state_nxt = tpm_pkg::FR_IDLE;
      default:          state_nxt = tpm_pkg::FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_full = 1'b1;
    q_push  = 1'b0;
    unique case (state_r)
      tpm_pkg::FR_IDLE: in_full = 1'b0;
      tpm_pkg::FR_ITER: in_full = 1'b1;
      tpm_pkg::FR_PUSH: q_push  = !q_stat.full;
      default:          in_full = 1'b1;
    endcase
  end

  assign q_data.rate = rate_r;
  assign q_data.acc  = z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpm_pkg::FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    cnt_r  <= cnt_nxt;
    rate_r <= rate_nxt;
  end

endmodule

@@ design/tpm_fifo.sv @@
// tpm_fifo: short register queue of classified samples between front and back.
// Depends on tpm_pkg.
`timescale 1ns / 1ps

module tpm_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tpm_pkg::sample_t  wr_data,
  input  logic              pop,
  output tpm_pkg::sample_t  rd_data,
  output tpm_pkg::q_stat_t  stat
);

  tpm_pkg::sample_t                mem_r [tpm_pkg::FIFO_DEPTH];
  logic [tpm_pkg::FIFO_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [tpm_pkg::FIFO_CNT_W-1:0]  cnt_r;
  logic                            do_push, do_pop;

  assign stat.full  = (cnt_r == tpm_pkg::FIFO_CNT_W'(tpm_pkg::FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

@@ design/tpm_back.sv @@
// tpm_back: complementary filter, PID and motor mixing on one shared
// multiplier, plus the result register. Depends on tpm_pkg.
`timescale 1ns / 1ps

module tpm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tpm_pkg::cfg_t       cfg,
  input  tpm_pkg::sample_t    q_data,
  input  tpm_pkg::q_stat_t    q_stat,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [7:0]          out_duty_left,
  output logic [7:0]          out_duty_right,
  output logic signed [8:0]   out_drive_level,
  output logic signed [16:0]  out_tilt_angle
);

  localparam int W = tpm_pkg::WIDE_W;

  tpm_pkg::back_state_t state_r, state_nxt;

  // filter and PID state
  logic signed [31:0]                tilt_r, tilt_nxt, integ_r, integ_nxt, prev_r, prev_nxt;
  // per-sample working registers
  logic signed [tpm_pkg::RATE_W-1:0] rate_r, rate_nxt, t_r, t_nxt, diff_r, diff_nxt;
  logic signed [tpm_pkg::ANG_W-1:0]  acc_r, acc_nxt;
  logic signed [31:0]                err_r, err_nxt;
  logic signed [W-1:0]               m_r, m_nxt, s_r, s_nxt;
  logic [tpm_pkg::N_W-1:0]           n_r, n_nxt;
  // result register
  logic                              out_valid_r, out_valid_nxt;
  logic [7:0]                        dl_r, dl_nxt, dr_r, dr_nxt;
  logic signed [8:0]                 drv_r, drv_nxt;
  logic signed [16:0]                tq_r, tq_nxt;

  logic signed [tpm_pkg::MUL_A_W-1:0] mul_a;
  logic signed [tpm_pkg::MUL_B_W-1:0] mul_b;
  logic signed [W-1:0]                mul_p;

  logic                  emit_ok;
  logic signed [W-1:0]   sdiv, sclamp;
  logic [15:0]           vsh;
  logic [9:0]            q10;
  logic signed [10:0]    drv11, dl11, dr11;
  logic signed [23:0]    tsh;

  assign emit_ok = !out_valid_r || out_pop;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      tpm_pkg::BK_RMUL:  begin mul_a = rate_r;                      mul_b = tpm_pkg::K_DT;    end
      tpm_pkg::BK_PRED:  begin mul_a = tpm_pkg::MUL_A_W'(acc_r);    mul_b = tpm_pkg::K_BETA;  end
      tpm_pkg::BK_ALPHA: begin mul_a = t_r;                         mul_b = tpm_pkg::K_ALPHA; end
      tpm_pkg::BK_IMUL:  begin mul_a = tpm_pkg::MUL_A_W'(err_r);    mul_b = tpm_pkg::K_DT;    end
      tpm_pkg::BK_INTEG: begin
        mul_a = tpm_pkg::MUL_A_W'(err_r);
        mul_b = $signed({7'b0, cfg.prop_gain});
      end
      tpm_pkg::BK_SUMP:  begin
        mul_a = tpm_pkg::MUL_A_W'(integ_r);
        mul_b = $signed({7'b0, cfg.integral_gain});
      end
      tpm_pkg::BK_SUMI:  begin mul_a = diff_r; mul_b = $signed({7'b0, cfg.deriv_gain}); end
      tpm_pkg::BK_RECIP: begin
        mul_a = $signed({{(tpm_pkg::MUL_A_W-tpm_pkg::N_W){1'b0}}, n_r});
        mul_b = tpm_pkg::K_RECIP;
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = W'(mul_a) * W'(mul_b);

  // PID output truncated toward zero, then limited to the remap span
  always_comb begin
    sdiv = (s_r + (s_r[W-1] ? $signed(W'(24'hff_ffff)) : W'(0))) >>> 24;
    if (sdiv > W'(30000)) begin
      sclamp = W'(30000);
    end else if (sdiv < -W'(30000)) begin
      sclamp = -W'(30000);
    end else begin
      sclamp = sdiv;
    end
    vsh = 16'(sclamp + W'(30000));
  end

  // remap and mixing
  always_comb begin
    q10   = m_r[tpm_pkg::RECIP_SH+9:tpm_pkg::RECIP_SH];
    drv11 = $signed({1'b0, q10}) - 11'sd255;
    dl11  = $signed({3'b0, cfg.base_speed_left}) - drv11;
    dr11  = $signed({3'b0, cfg.base_speed_right}) + drv11;
    tsh   = 24'(tilt_r >>> 8);
  end

  // datapath
  always_comb begin
    tilt_nxt  = tilt_r;
    integ_nxt = integ_r;
    prev_nxt  = prev_r;
    rate_nxt  = rate_r;
    acc_nxt   = acc_r;
    t_nxt     = t_r;
    diff_nxt  = diff_r;
    err_nxt   = err_r;
    m_nxt     = m_r;
    s_nxt     = s_r;
    n_nxt     = n_r;
    dl_nxt    = dl_r;
    dr_nxt    = dr_r;
    drv_nxt   = drv_r;
    tq_nxt    = tq_r;
    case (state_r)
      tpm_pkg::BK_IDLE: begin
        rate_nxt = q_data.rate;
        acc_nxt  = q_data.acc;
      end
      tpm_pkg::BK_RMUL:  m_nxt = mul_p;
      tpm_pkg::BK_PRED: begin
        // predicted tilt from the integrated rate
        t_nxt = tpm_pkg::RATE_W'(tilt_r) + tpm_pkg::RATE_W'(m_r >>> 16);
        m_nxt = mul_p;
      end
      tpm_pkg::BK_ALPHA: begin
        s_nxt = m_r;
        m_nxt = mul_p;
      end
      tpm_pkg::BK_TILT:  tilt_nxt = tpm_pkg::sat32((m_r + s_r) >>> 16);
      tpm_pkg::BK_ERR:   err_nxt = tpm_pkg::sat32(-W'(tilt_r) - W'(rate_r));
      tpm_pkg::BK_IMUL: begin
        m_nxt    = mul_p;
        diff_nxt = tpm_pkg::RATE_W'(err_r) - tpm_pkg::RATE_W'(prev_r);
        prev_nxt = err_r;
      end
      tpm_pkg::BK_INTEG: begin
        integ_nxt = tpm_pkg::sat32(W'(integ_r) + (m_r >>> 16));
        m_nxt     = mul_p;
      end
      tpm_pkg::BK_SUMP: begin
        s_nxt = m_r;
        m_nxt = mul_p;
      end
      tpm_pkg::BK_SUMI: begin
        s_nxt = s_r + m_r;
        m_nxt = mul_p;
      end
      // derivative term times 100 = 64 + 32 + 4
      tpm_pkg::BK_D100:  m_nxt = (m_r <<< 6) + (m_r <<< 5) + (m_r <<< 2);
      tpm_pkg::BK_SUMD:  s_nxt = s_r + m_r;
      tpm_pkg::BK_OUT:   n_nxt = {vsh, 4'b0} + tpm_pkg::N_W'(vsh);
      tpm_pkg::BK_RECIP: m_nxt = mul_p;
      tpm_pkg::BK_EMIT: begin
        if (emit_ok) begin
          drv_nxt = drv11[8:0];
          if (dl11 < 11'sd0) begin
            dl_nxt = 8'd0;
          end else if (dl11 > $signed({3'b0, cfg.duty_limit})) begin
            dl_nxt = cfg.duty_limit;
          end else begin
            dl_nxt = dl11[7:0];
          end
          if (dr11 < 11'sd0) begin
            dr_nxt = 8'd0;
          end else if (dr11 > $signed({3'b0, cfg.duty_limit})) begin
            dr_nxt = cfg.duty_limit;
          end else begin
            dr_nxt = dr11[7:0];
          end
          if (tsh > 24'sd46080) begin
            tq_nxt = 17'sd46080;
          end else if (tsh < -24'sd46080) begin
            tq_nxt = -17'sd46080;
          end else begin
            tq_nxt = tsh[16:0];
          end
        end
      end
      default: m_nxt = m_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpm_pkg::BK_IDLE:  if (!q_stat.empty) state_nxt = tpm_pkg::BK_RMUL;
      tpm_pkg::BK_RMUL:  state_nxt = tpm_pkg::BK_PRED;
      tpm_pkg::BK_PRED:  state_nxt = tpm_pkg::BK_ALPHA;
      tpm_pkg::BK_ALPHA: state_nxt = tpm_pkg::BK_TILT;
      tpm_pkg::BK_TILT:  state_nxt = tpm_pkg::BK_ERR;
      tpm_pkg::BK_ERR:   state_nxt = tpm_pkg::BK_IMUL;
      tpm_pkg::BK_IMUL:  state_nxt = tpm_pkg::BK_INTEG;
      tpm_pkg::BK_INTEG: state_nxt = tpm_pkg::BK_SUMP;
      tpm_pkg::BK_SUMP:  state_nxt = tpm_pkg::BK_SUMI;
      tpm_pkg::BK_SUMI:  state_nxt = tpm_pkg::BK_D100;
      tpm_pkg::BK_D100:  state_nxt = tpm_pkg::BK_SUMD;
      tpm_pkg::BK_SUMD:  state_nxt = tpm_pkg::BK_OUT;
      tpm_pkg::BK_OUT:   state_nxt = tpm_pkg::BK_RECIP;
      tpm_pkg::BK_RECIP: state_nxt = tpm_pkg::BK_EMIT;
      tpm_pkg::BK_EMIT:  if (emit_ok) state_nxt = tpm_pkg::BK_IDLE;
      default:           state_nxt = tpm_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && !out_pop;
    unique case (state_r)
      tpm_pkg::BK_IDLE: q_pop = !q_stat.empty;
      tpm_pkg::BK_EMIT: if (emit_ok) out_valid_nxt = 1'b1;
      default:          q_pop = 1'b0;
    endcase
  end

  assign out_empty       = !out_valid_r;
  assign out_duty_left   = dl_r;
  assign out_duty_right  = dr_r;
  assign out_drive_level = drv_r;
  assign out_tilt_angle  = tq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpm_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      tilt_r      <= '0;
      integ_r     <= '0;
      prev_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tilt_r      <= tilt_nxt;
      integ_r     <= integ_nxt;
      prev_r      <= prev_nxt;
    end
    rate_r <= rate_nxt;
    acc_r  <= acc_nxt;
    t_r    <= t_nxt;
    diff_r <= diff_nxt;
    err_r  <= err_nxt;
    m_r    <= m_nxt;
    s_r    <= s_nxt;
    n_r    <= n_nxt;
    dl_r   <= dl_nxt;
    dr_r   <= dr_nxt;
    drv_r  <= drv_nxt;
    tq_r   <= tq_nxt;
  end

  // checks
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_drive_level != -9'sd256))
    else $error("drive level outside +-255");

  a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_duty_left <= cfg.duty_limit) && (out_duty_right <= cfg.duty_limit))
    else $error("duty above limit");

  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_tilt_angle <= 17'sd46080) && (out_tilt_angle >= -17'sd46080))
    else $error("tilt angle out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tpm_pkg::BK_EMIT) && out_valid_r && !out_pop |=> (state_r == tpm_pkg::BK_EMIT))
    else $error("result overwritten while waiting");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tpm_pkg::BK_IDLE) && !q_stat.empty |=> (state_r == tpm_pkg::BK_RMUL))
    else $error("queued sample not started");

endmodule

@@ design/tilt_pid_motor_mixer.sv @@
// tilt_pid_motor_mixer: top level with configuration registers, front,
// queue and back. Depends on tpm_pkg, tpm_front, tpm_fifo, tpm_back.
//
// Usage:
//  Input channel: drive in_accel_y, in_accel_z, in_gyro_x and raise in_push;
//  a sample is taken on a clock edge where in_push is high and in_full low.
//  Result channel: while out_empty is low the ports carry the oldest result
//  (duties, drive level, tilt angle); it is taken when out_pop is high.
//  Configuration: cfg_wr_en, cfg_index, cfg_data write one register per
//  clock; write only while no sample is in flight. Index 7 is ignored.
//  Path: from the accepting edge to out_empty falling a sample runs the 16
//  CORDIC rotations (skipped when both accel axes are zero) and the push
//  state in the front, then the back's state sequence on its one multiplier.
//  Overlap: the front takes a new sample only once its CORDIC loop and push
//  are done; the back's sequence overlaps it through a two-word queue.
//  Reset (rst_n low, synchronous): registers to their defaults, filter and
//  PID state to zero, queue and result register empty.
//  When the receiver stalls the result holds, the back waits, the queue
//  fills and in_full then stays high until words drain.
`timescale 1ns / 1ps

module tilt_pid_motor_mixer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic signed [15:0]               in_accel_y,
  input  logic signed [15:0]               in_accel_z,
  input  logic signed [15:0]               in_gyro_x,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [7:0]                       out_duty_left,
  output logic [7:0]                       out_duty_right,
  output logic signed [8:0]                out_drive_level,
  output logic signed [16:0]               out_tilt_angle,
  input  logic                             cfg_wr_en,
  input  logic [tpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data
);

  tpm_pkg::cfg_t     cfg_r, cfg_nxt;
  tpm_pkg::sample_t  f_data, b_data;
  tpm_pkg::q_stat_t  q_stat;
  logic              q_push, q_pop;

  // configuration register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        tpm_pkg::CFG_GYRO_OFFSET: cfg_nxt.gyro_rate_offset = cfg_data;
        tpm_pkg::CFG_PROP_GAIN:   cfg_nxt.prop_gain        = cfg_data;
        tpm_pkg::CFG_INTEG_GAIN:  cfg_nxt.integral_gain    = cfg_data;
        tpm_pkg::CFG_DERIV_GAIN:  cfg_nxt.deriv_gain       = cfg_data;
        tpm_pkg::CFG_BASE_LEFT:   cfg_nxt.base_speed_left  = cfg_data[7:0];
        tpm_pkg::CFG_BASE_RIGHT:  cfg_nxt.base_speed_right = cfg_data[7:0];
        tpm_pkg::CFG_DUTY_LIMIT:  cfg_nxt.duty_limit       = cfg_data[7:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gyro_rate_offset <= 16'sd0;
      cfg_r.prop_gain        <= 16'd1536;
      cfg_r.integral_gain    <= 16'd154;
      cfg_r.deriv_gain       <= 16'd6400;
      cfg_r.base_speed_left  <= 8'd125;
      cfg_r.base_speed_right <= 8'd125;
      cfg_r.duty_limit       <= 8'd125;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tpm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_accel_y       (in_accel_y),
    .in_accel_z       (in_accel_z),
    .in_gyro_x        (in_gyro_x),
    .gyro_rate_offset (cfg_r.gyro_rate_offset),
    .q_push           (q_push),
    .q_data           (f_data),
    .q_stat           (q_stat)
  );

  tpm_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (f_data),
    .pop     (q_pop),
    .rd_data (b_data),
    .stat    (q_stat)
  );

  tpm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_data          (b_data),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_duty_left   (out_duty_left),
    .out_duty_right  (out_duty_right),
    .out_drive_level (out_drive_level),
    .out_tilt_angle  (out_tilt_angle)
  );

endmodule

@@ tb/sv/testbench.sv @@
// testbench: self-checking bench for tilt_pid_motor_mixer (directed table, extreme settings,
// then random words). Depends on tpm_pkg and the design top; all prediction is done locally.
`timescale 1ns / 1ps

module testbench;

  localparam int N_RANDOM  = 1300;
  localparam int LAT       = 80;
  localparam longint LIMIT = 2_000_000;
  localparam longint A180  = 64'sd11796480;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint S32_MAX = 64'sd2147483647;

  typedef struct {
    logic [7:0]         duty_left;
    logic [7:0]         duty_right;
    logic signed [8:0]  drive_level;
    logic signed [16:0] tilt_angle;
  } mix_res_t;

  typedef struct {
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gx;
    bit                 fixed;   // expected result typed in below
    mix_res_t           res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [15:0] in_accel_y = '0, in_accel_z = '0, in_gyro_x = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [7:0] out_duty_left, out_duty_right;
  logic signed [8:0] out_drive_level;
  logic signed [16:0] out_tilt_angle;
  logic cfg_wr_en = 1'b0;
  logic [tpm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #4 clk = ~clk;

  tilt_pid_motor_mixer u_top (.*);

  // local copy of registers and filter state
  logic signed [15:0] m_offset;
  logic [15:0] m_kp, m_ki, m_kd;
  logic [7:0]  m_base_l, m_base_r, m_limit;
  longint m_tilt, m_integ, m_prev_err;

  mix_res_t duty_q[$];
  int  n_err = 0, n_words = 0;
  longint cycles = 0;
  bit  feeding = 1'b1;
  int  stall_pct = 0;

  const longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint accel_angle(longint a, longint b);
    longint x, y, z, xs, ys;
    x = b * 65536; y = a * 65536; z = 0;
    if (a == 0 && b == 0) return 0;
    if (x < 0) begin
      x = -x; y = -y;
      z = (a >= 0) ? A180 : -A180;
    end
    for (int i = 0; i < tpm_pkg::CORDIC_STEPS && i < 24; i++) begin
      xs = floor_shr(x, i); ys = floor_shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_tab[i];
      end else begin
        x -= ys; y += xs; z -= atan_tab[i];
      end
    end
    return z;
  endfunction

  // one filter and PID update; advances the local state
  function automatic mix_res_t mix_sample(logic signed [15:0] ay, logic signed [15:0] az,
                                          logic signed [15:0] gx);
    mix_res_t r;
    longint rate, acc, t, err, derr, sum, drv;
    rate = (longint'(gx) - longint'(m_offset)) * 40042;
    acc  = accel_angle(-longint'(ay), longint'(az));
    t    = m_tilt + floor_shr(rate * 655, 16);
    m_tilt = clip(floor_shr(t * 62259 + acc * 3277, 16), S32_MIN, S32_MAX);
    err  = clip(-m_tilt - rate, S32_MIN, S32_MAX);
    m_integ = clip(m_integ + floor_shr(err * 655, 16), S32_MIN, S32_MAX);
    derr = (err - m_prev_err) * 100;
    m_prev_err = err;
    sum  = longint'(m_kp) * err + longint'(m_ki) * m_integ + longint'(m_kd) * derr;
    sum  = sum / 16777216;
    drv  = clip((sum + 30000) * 510 / 60000 - 255, -255, 255);
    r.duty_left   = 8'(clip(longint'(m_base_l) - drv, 0, longint'(m_limit)));
    r.duty_right  = 8'(clip(longint'(m_base_r) + drv, 0, longint'(m_limit)));
    r.drive_level = 9'(drv);
    r.tilt_angle  = 17'(clip(floor_shr(m_tilt, 8), -46080, 46080));
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    n_err++;
    $display("MISMATCH word %0d %s: got %0d expected %0d", n_words, what, got, want);
  endtask

  task automatic write_reg(logic [tpm_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      tpm_pkg::CFG_GYRO_OFFSET: m_offset = val;
      tpm_pkg::CFG_PROP_GAIN:   m_kp = val;
      tpm_pkg::CFG_INTEG_GAIN:  m_ki = val;
      tpm_pkg::CFG_DERIV_GAIN:  m_kd = val;
      tpm_pkg::CFG_BASE_LEFT:   m_base_l = val[7:0];
      tpm_pkg::CFG_BASE_RIGHT:  m_base_r = val[7:0];
      tpm_pkg::CFG_DUTY_LIMIT:  m_limit = val[7:0];
      default: ;
    endcase
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // push one sample; expected result is the predictor's unless given
  task automatic send_word(logic signed [15:0] ay, logic signed [15:0] az,
                           logic signed [15:0] gx, bit fixed, mix_res_t want);
    mix_res_t p;
    int g;
    g = gap_len();
    if (g != 0) begin
      in_push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_push <= 1'b1; in_accel_y <= ay; in_accel_z <= az; in_gyro_x <= gx;
    p = mix_sample(ay, az, gx);
    duty_q.push_back(fixed ? want : p);
    do @(posedge clk); while (in_full);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (duty_q.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  // result side: random stalls while stall_pct is set, compare each word with the oldest expectation
  always @(posedge clk) begin
    mix_res_t w;
    if (rst_n && out_pop && !out_empty) begin
      n_words++;
      if (duty_q.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        w = duty_q.pop_front();
        if (out_duty_left !== w.duty_left)   report("duty_left", out_duty_left, w.duty_left);
        if (out_duty_right !== w.duty_right)
          report("duty_right", out_duty_right, w.duty_right);
        if (out_drive_level !== w.drive_level)
          report("drive_level", out_drive_level, w.drive_level);
        if (out_tilt_angle !== w.tilt_angle)
          report("tilt_angle", out_tilt_angle, w.tilt_angle);
      end
    end
    if (stall_pct == 0) out_pop <= 1'b1;
    else if ($urandom_range(0, 99) < 3) out_pop <= 1'b0;
    else out_pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $display("timeout after %0d cycles", cycles);
      $finish;
    end
  end

  // reset values of the local model
  task automatic model_reset();
    m_offset = 0; m_kp = 1536; m_ki = 154; m_kd = 6400;
    m_base_l = 125; m_base_r = 125; m_limit = 125;
    m_tilt = 0; m_integ = 0; m_prev_err = 0;
  endtask

  stim_row_t dir_tab[$];

  function automatic stim_row_t row(int ay, int az, int gx, bit fixed = 0,
                                    int dl = 0, int dr = 0, int dv = 0, int ta = 0);
    stim_row_t s;
    s.ay = 16'(ay); s.az = 16'(az); s.gx = 16'(gx); s.fixed = fixed;
    s.res.duty_left = 8'(dl); s.res.duty_right = 8'(dr); s.res.drive_level = 9'(dv);
    s.res.tilt_angle = 17'(ta);
    return s;
  endfunction

  initial begin
    logic signed [15:0] ay, az, gx;
    mix_res_t none;
    none = '{default: '0};
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first row from reset state with all zero is a known rest point
    dir_tab.push_back(row(0, 0, 0, 1, 125, 125, 0, 0));
    dir_tab.push_back(row(0, 16384, 0));
    dir_tab.push_back(row(0, -16384, 0));      // accel_z negative, -ay >= 0
    dir_tab.push_back(row(1000, -16384, 0));   // accel_z negative, -ay < 0
    dir_tab.push_back(row(-1000, -1, 0));
    dir_tab.push_back(row(16384, 0, 0));
    dir_tab.push_back(row(-16384, 0, 0));
    dir_tab.push_back(row(32767, 32767, 32767));
    dir_tab.push_back(row(-32768, -32768, -32768));
    dir_tab.push_back(row(-32768, 32767, 32767));
    dir_tab.push_back(row(32767, -32768, -32768));
    dir_tab.push_back(row(0, 0, 32767));
    dir_tab.push_back(row(0, 0, -32768));
    dir_tab.push_back(row(-1, 1, -1));
    dir_tab.push_back(row(1, -1, 1));
    foreach (dir_tab[i]) send_word(dir_tab[i].ay, dir_tab[i].az, dir_tab[i].gx,
                                   dir_tab[i].fixed, dir_tab[i].res);
    drain();

    // extreme register settings; index 7 must be ignored
    write_reg(tpm_pkg::CFG_GYRO_OFFSET, 16'h8000);
    write_reg(tpm_pkg::CFG_PROP_GAIN, 16'hFFFF);
    write_reg(tpm_pkg::CFG_INTEG_GAIN, 16'hFFFF);
    write_reg(tpm_pkg::CFG_DERIV_GAIN, 16'hFFFF);
    write_reg(tpm_pkg::CFG_BASE_LEFT, 16'h00FF);
    write_reg(tpm_pkg::CFG_BASE_RIGHT, 16'h0000);
    write_reg(tpm_pkg::CFG_DUTY_LIMIT, 16'h00FF);
    write_reg(3'd7, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_word(16'sh7FFF, 16'sh8000, 16'sh7FFF, 0, none);
    for (int i = 0; i < 4; i++) send_word(16'sh8000, 16'sh7FFF, 16'sh8000, 0, none);
    drain();

    // random phases with varied settings and back-pressure
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(tpm_pkg::CFG_GYRO_OFFSET, 16'h7FFF);
          write_reg(tpm_pkg::CFG_PROP_GAIN, 16'h0000);
          write_reg(tpm_pkg::CFG_INTEG_GAIN, 16'h0000);
          write_reg(tpm_pkg::CFG_DERIV_GAIN, 16'h0000);
          write_reg(tpm_pkg::CFG_DUTY_LIMIT, 16'h0000);
        end
        1: begin
          write_reg(tpm_pkg::CFG_GYRO_OFFSET, 16'h0000);
          write_reg(tpm_pkg::CFG_PROP_GAIN, 16'd1536);
          write_reg(tpm_pkg::CFG_INTEG_GAIN, 16'd154);
          write_reg(tpm_pkg::CFG_DERIV_GAIN, 16'd6400);
          write_reg(tpm_pkg::CFG_BASE_LEFT, 16'd125);
          write_reg(tpm_pkg::CFG_BASE_RIGHT, 16'd125);
          write_reg(tpm_pkg::CFG_DUTY_LIMIT, 16'd125);
        end
        default: begin
          for (int r = 0; r < 7; r++)
            write_reg(r[tpm_pkg::CFG_IDX_W-1:0], 16'($urandom));
        end
      endcase
      stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 70);
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          // mostly moderate, sensor-like samples
          ay = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
          az = $signed(16'($urandom_range(0, 40000))) - 16'sd12000;
          gx = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
        end else begin
          ay = 16'($urandom); az = 16'($urandom); gx = 16'($urandom);
        end
        send_word(ay, az, gx, 0, none);
      end
      stall_pct = 0;
      drain();
    end

    $display("Covered %0d result words over the directed table and six register settings.",
             n_words);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
